### rtl/tqg_pkg.sv
// ----------------------------------------------------------------------------
// tqg_pkg
// Shared types, constants and helper functions of the tile quad generator.
// ----------------------------------------------------------------------------
package tqg_pkg;

  localparam int unsigned ID_W        = 24;
  localparam int unsigned FLIP_W      = 3;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned TPR_W       = 11;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned SX_W        = 18;
  localparam int unsigned SY_W        = 19;
  localparam int unsigned TEX_W       = 32;
  localparam int unsigned U0_W        = TPR_W + DIM_W;
  localparam int unsigned V0_W        = ID_W + DIM_W;
  localparam int unsigned CHUNK_TILES = 512;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  localparam logic [2:0] REG_FIRST_ID      = 3'd0;
  localparam logic [2:0] REG_LAST_ID       = 3'd1;
  localparam logic [2:0] REG_TILES_PER_ROW = 3'd2;
  localparam logic [2:0] REG_SHEET_W       = 3'd3;
  localparam logic [2:0] REG_SHEET_H       = 3'd4;
  localparam logic [2:0] REG_GRID_W        = 3'd5;
  localparam logic [2:0] REG_GRID_H        = 3'd6;

  typedef struct packed {
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  last_id;
    logic [TPR_W-1:0] tiles_per_row;
    logic [DIM_W-1:0] sheet_w;
    logic [DIM_W-1:0] sheet_h;
    logic [DIM_W-1:0] grid_w;
    logic [DIM_W-1:0] grid_h;
  } cfg_t;

  // one restoring-division step: remainder and dividend/quotient shift word
  typedef struct packed {
    logic [TPR_W-1:0] rem;
    logic [ID_W-1:0]  num;
  } div_t;

  // tile after sheet index split, passed from front to back
  typedef struct packed {
    logic [ID_W-1:0]   quot;
    logic [TPR_W-1:0]  rem;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [FLIP_W-1:0] flips;
  } tile_t;

  function automatic div_t div_step(div_t s, logic [TPR_W-1:0] d);
    logic [TPR_W:0] r2;
    logic           bit_q;
    div_t           n;
    r2    = {s.rem, s.num[ID_W-1]};
    bit_q = (r2 >= {1'b0, d});
    n.rem = bit_q ? TPR_W'(r2 - {1'b0, d}) : TPR_W'(r2);
    n.num = {s.num[ID_W-2:0], bit_q};
    return n;
  endfunction

  // returns {u_far, v_far}: whether the corner takes the +width / +height edge
  function automatic logic [1:0] tex_sel(logic [FLIP_W-1:0] flips, logic [1:0] corner);
    logic       fh;
    logic       fv;
    logic       fd;
    logic       mx;
    logic       my;
    logic [1:0] src;
    fh  = flips[2];
    fv  = flips[1];
    fd  = flips[0];
    mx  = fd ? fv : fh;
    my  = fd ? fh : fv;
    // diagonal flip exchanges corners 1 and 3
    src = (fd && corner[0]) ? (corner ^ 2'b10) : corner;
    return {(src[0] ^ src[1]) ^ mx, src[1] ^ my};
  endfunction

endpackage

### rtl/tqg_regs.sv
// ----------------------------------------------------------------------------
// tqg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module tqg_regs import tqg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FIRST_ID:      cfg_d.first_id      = pwdata[ID_W-1:0];
        REG_LAST_ID:       cfg_d.last_id       = pwdata[ID_W-1:0];
        REG_TILES_PER_ROW: cfg_d.tiles_per_row = pwdata[TPR_W-1:0];
        REG_SHEET_W:       cfg_d.sheet_w       = pwdata[DIM_W-1:0];
        REG_SHEET_H:       cfg_d.sheet_h       = pwdata[DIM_W-1:0];
        REG_GRID_W:        cfg_d.grid_w        = pwdata[DIM_W-1:0];
        REG_GRID_H:        cfg_d.grid_h        = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_id      <= ID_W'(1);
      cfg_q.last_id       <= '1;
      cfg_q.tiles_per_row <= TPR_W'(1);
      cfg_q.sheet_w       <= DIM_W'(16);
      cfg_q.sheet_h       <= DIM_W'(16);
      cfg_q.grid_w        <= DIM_W'(16);
      cfg_q.grid_h        <= DIM_W'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_FIRST_ID:      prdata = DATA_W'(cfg_q.first_id);
      REG_LAST_ID:       prdata = DATA_W'(cfg_q.last_id);
      REG_TILES_PER_ROW: prdata = DATA_W'(cfg_q.tiles_per_row);
      REG_SHEET_W:       prdata = DATA_W'(cfg_q.sheet_w);
      REG_SHEET_H:       prdata = DATA_W'(cfg_q.sheet_h);
      REG_GRID_W:        prdata = DATA_W'(cfg_q.grid_w);
      REG_GRID_H:        prdata = DATA_W'(cfg_q.grid_h);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/tqg_front.sv
// ----------------------------------------------------------------------------
// tqg_front
// Accepts tiles, drops out-of-range ones and splits the sheet index into
// column and row with a pipelined restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module tqg_front import tqg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [ID_W-1:0]   tile_id_i,
  input  logic [FLIP_W-1:0] flip_bits_i,
  input  logic [POS_W-1:0]  tile_column_i,
  input  logic [POS_W-1:0]  tile_row_i,
  output logic              q_push_o,
  input  logic              q_full_i,
  output tile_t             q_data_o
);

  localparam int unsigned STAGES = ID_W;

  typedef struct packed {
    div_t              div;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [FLIP_W-1:0] flips;
  } stage_t;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  stage_t            stg_q [STAGES];
  stage_t            stg_d [STAGES];
  logic              adv;
  logic              take;
  logic              in_range;
  logic [TPR_W-1:0]  per_row;
  div_t              init;

  assign adv      = !(vld_q[STAGES-1] && q_full_i);
  assign full_o   = !adv;
  assign q_push_o = vld_q[STAGES-1] && !q_full_i;
  assign per_row  = (cfg_i.tiles_per_row == '0) ? TPR_W'(1) : cfg_i.tiles_per_row;

  assign in_range = (tile_id_i >= cfg_i.first_id) && (tile_id_i <= cfg_i.last_id)
                  && (32'(tile_column_i) < CHUNK_TILES) && (32'(tile_row_i) < CHUNK_TILES);
  assign take     = push_i && adv && in_range;
  assign init.rem = '0;
  assign init.num = tile_id_i - cfg_i.first_id;

  always_comb begin
    vld_d         = {vld_q[STAGES-2:0], take};
    stg_d[0].div   = div_step(init, per_row);
    stg_d[0].col   = tile_column_i;
    stg_d[0].row   = tile_row_i;
    stg_d[0].flips = flip_bits_i;
    for (int s = 1; s < STAGES; s++) begin
      stg_d[s]     = stg_q[s-1];
      stg_d[s].div = div_step(stg_q[s-1].div, per_row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < STAGES; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign q_data_o.quot  = stg_q[STAGES-1].div.num;
  assign q_data_o.rem   = stg_q[STAGES-1].div.rem;
  assign q_data_o.col   = stg_q[STAGES-1].col;
  assign q_data_o.row   = stg_q[STAGES-1].row;
  assign q_data_o.flips = stg_q[STAGES-1].flips;

endmodule

### rtl/tqg_fifo.sv
// ----------------------------------------------------------------------------
// tqg_fifo
// Short queue of classified tiles between front and back.
// ----------------------------------------------------------------------------
module tqg_fifo import tqg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tile_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output tile_t data_o
);

  tile_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] wr_d;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W-1:0] rd_d;
  logic [QPTR_W:0]   cnt_q;
  logic [QPTR_W:0]   cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/tqg_back.sv
// ----------------------------------------------------------------------------
// tqg_back
// Scales a classified tile into base positions, then emits its four corner
// vertices through an output register, applying the flip permutation.
// ----------------------------------------------------------------------------
module tqg_back import tqg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_empty_i,
  input  tile_t               q_data_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          corner_o,
  output logic [SX_W-1:0]     screen_x_o,
  output logic signed [SY_W-1:0] screen_y_o,
  output logic [TEX_W-1:0]    tex_u_o,
  output logic [TEX_W-1:0]    tex_v_o,
  output logic                last_corner_o
);

  // base products of the tile in flight
  logic                p_vld_q;
  logic [1:0]          cnt_q;
  logic [U0_W-1:0]     u0_q;
  logic [V0_W-1:0]     v0_q;
  logic [SX_W-1:0]     colp_q;
  logic [SX_W-1:0]     rowp_q;
  logic [FLIP_W-1:0]   flips_q;

  logic                o_vld_q;
  logic [1:0]          o_corner_q;
  logic [SX_W-1:0]     o_sx_q;
  logic [SY_W-1:0]     o_sy_q;
  logic [TEX_W-1:0]    o_u_q;
  logic [TEX_W-1:0]    o_v_q;

  logic                o_adv;
  logic                emit;
  logic                p_load;
  logic [1:0]          sel;
  logic [TEX_W-1:0]    u_sum;
  logic [V0_W:0]       v_sum;
  logic [SX_W-1:0]     sx;
  logic [SY_W-1:0]     sy;

  assign o_adv   = !o_vld_q || pop;
  assign emit    = p_vld_q && o_adv;
  assign p_load  = !q_empty_i && (!p_vld_q || (emit && cnt_q == 2'd3));
  assign q_pop_o = p_load;

  always_comb begin
    sel   = tex_sel(flips_q, cnt_q);
    u_sum = TEX_W'(u0_q) + (sel[1] ? TEX_W'(cfg_i.sheet_w) : '0);
    v_sum = (V0_W+1)'(v0_q) + (sel[0] ? (V0_W+1)'(cfg_i.sheet_h) : '0);
    sx    = colp_q + ((cnt_q[0] ^ cnt_q[1]) ? SX_W'(cfg_i.sheet_w) : '0);
    sy    = SY_W'(rowp_q) + SY_W'(cfg_i.grid_h) - (cnt_q[1] ? '0 : SY_W'(cfg_i.sheet_h));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      cnt_q   <= '0;
      o_vld_q <= 1'b0;
    end else begin
      if (p_load) begin
        p_vld_q <= 1'b1;
        cnt_q   <= '0;
      end else if (emit) begin
        p_vld_q <= (cnt_q != 2'd3);
        cnt_q   <= cnt_q + 2'd1;
      end
      if (o_adv) begin
        o_vld_q <= p_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      u0_q    <= U0_W'(q_data_i.rem) * U0_W'(cfg_i.sheet_w);
      v0_q    <= V0_W'(q_data_i.quot) * V0_W'(cfg_i.sheet_h);
      colp_q  <= SX_W'(q_data_i.col) * SX_W'(cfg_i.grid_w);
      rowp_q  <= SX_W'(q_data_i.row) * SX_W'(cfg_i.grid_h);
      flips_q <= q_data_i.flips;
    end
    if (emit) begin
      o_corner_q <= cnt_q;
      o_sx_q     <= sx;
      o_sy_q     <= sy;
      o_u_q      <= u_sum;
      o_v_q      <= (v_sum[V0_W:TEX_W] != '0) ? '1 : v_sum[TEX_W-1:0];
    end
  end

  assign empty         = !o_vld_q;
  assign corner_o      = o_corner_q;
  assign screen_x_o    = o_sx_q;
  assign screen_y_o    = o_sy_q;
  assign tex_u_o       = o_u_q;
  assign tex_v_o       = o_v_q;
  assign last_corner_o = (o_corner_q == 2'd3);

endmodule

### rtl/tile_quad_generator.sv
// ----------------------------------------------------------------------------
// tile_quad_generator
// Turns map tiles into the four corner vertices of a textured quad.
//
//   channel   handshake            payload
//   tile in   push / full          tile_id_i, flip_bits_i, tile_column_i,
//                                  tile_row_i
//   vertex    empty / pop          corner_o, screen_x_o, screen_y_o,
//                                  tex_u_o, tex_v_o, last_corner_o
//   config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A tile in range produces four vertices, one per cycle while pop keeps the
// output register draining, so the sustained tile rate is set by the single
// vertex output port. Before its first vertex is on the outputs, a tile
// enters the first of 24 divider stages at the accepting edge, then
// passes the tile queue, the scaling register and the output register.
// Out-of-range tiles are dropped at the input.
// full rises when the divider pipeline is blocked by a full tile queue.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module tile_quad_generator import tqg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   push,
  output logic                   full,
  input  logic [ID_W-1:0]        tile_id_i,
  input  logic [FLIP_W-1:0]      flip_bits_i,
  input  logic [POS_W-1:0]       tile_column_i,
  input  logic [POS_W-1:0]       tile_row_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             corner_o,
  output logic [SX_W-1:0]        screen_x_o,
  output logic signed [SY_W-1:0] screen_y_o,
  output logic [TEX_W-1:0]       tex_u_o,
  output logic [TEX_W-1:0]       tex_v_o,
  output logic                   last_corner_o
);

  cfg_t  cfg;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  tile_t q_wdata;
  tile_t q_rdata;

  tqg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tqg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .push_i        (push),
    .full_o        (full),
    .tile_id_i     (tile_id_i),
    .flip_bits_i   (flip_bits_i),
    .tile_column_i (tile_column_i),
    .tile_row_i    (tile_row_i),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_data_o      (q_wdata)
  );

  tqg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  tqg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .corner_o      (corner_o),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .last_corner_o (last_corner_o)
  );

endmodule
